// ===== sv/sqpi_pkg.sv =====
// shared types, constants and tables of the spline pose interpolator
package sqpi_pkg;

    // default depth of the key store in keyframes
    localparam int MAX_KEYS_DEF = 16;
    // fraction bits of keys, channels and matrix elements
    localparam int FRAC_BITS    = 16;
    // channels per keyframe
    localparam int NCHAN        = 7;

    // configuration register indexes
    localparam logic [1:0] CFG_SPLINE_MODE = 2'd0;
    localparam logic [1:0] CFG_KEY_COUNT   = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP   = 2'd2;

    // configuration reset values
    localparam logic        SPLINE_MODE_RST = 1'b0;
    localparam logic [4:0]  KEY_COUNT_RST   = 5'd7;
    localparam logic [15:0] TIME_STEP_RST   = 16'd655;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // quaternion channel slots
    localparam int QW = 0;
    localparam int QX = 1;
    localparam int QY = 2;
    localparam int QZ = 3;

    // matrix element codes
    localparam logic [3:0] ELEM_LAST = 4'd15;
    localparam logic signed [31:0] ELEM_ONE = 32'sd1 <<< FRAC_BITS;

    // cubic basis scaled by 6, [mode][row*4+col]
    localparam int BASIS6 [2][16] = '{
        '{-3, 6, -3, 0,   9, -15, 0, 6,   -9, 12, 3, 0,   3, -3, 0, 0},
        '{-1, 3, -3, 1,   3, -6, 0, 4,    -3, 3, 3, 1,    1, 0, 0, 0}
    };

    // beat of the input channel
    typedef struct packed {
        logic               kind;
        logic [3:0]         key_index;
        logic [2:0]         channel;
        logic signed [31:0] key_value;
    } t_in_item;

    // beat of the output channel
    typedef struct packed {
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic               last;
    } t_out_item;

    // beat of the configuration channel
    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_item;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_USQ,
        ST_UCUBE,
        ST_WACC,
        ST_WPREP,
        ST_WDIV,
        ST_BLEND,
        ST_NSQ,
        ST_NSHIFT,
        ST_SQRT,
        ST_DSETUP,
        ST_DIV,
        ST_PROD,
        ST_EMIT
    } t_state;

    // quaternion product slots
    typedef enum logic [3:0] {
        PP_XX,
        PP_YY,
        PP_ZZ,
        PP_XY,
        PP_XZ,
        PP_YZ,
        PP_WX,
        PP_WY,
        PP_WZ
    } t_pp;

endpackage

// ===== sv/sqpi_stream_if.sv =====
// valid/ready channel carrying one payload beat
interface sqpi_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/spline_quaternion_pose_interpolator_top.sv =====
// keyframe pose interpolator: key store, spline blend, quaternion normalise, matrix out
//
// Load beats write one channel of one keyframe into a single-port key store. A tick beat
// blends four keys from the current segment with a Catmull-Rom or uniform B-spline basis
// at the current fraction, normalises the blended quaternion and sends the 4x4 column-major
// pose matrix as 16 output beats, element 15 marked last. Before its last beat is offered,
// a tick runs reciprocal multiplication for the basis weights, 28 reads of the key store
// through one registered read port, up to 30 normalising shifts, a 32-step square root and
// four 19-step divisions; a zero quaternion skips the root and the divisions. A new beat is
// taken once the last element is in the output register, while that element still waits.
// Reads of keys never written give undefined matrix elements.
module spline_quaternion_pose_interpolator_top #(
    parameter int MAX_KEYS = sqpi_pkg::MAX_KEYS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sqpi_stream_if.sink   i_cfg,
    sqpi_stream_if.sink   i_in,
    sqpi_stream_if.source o_out
);
    import sqpi_pkg::*;

    localparam int DEPTH  = MAX_KEYS * NCHAN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SEG_W  = $clog2(MAX_KEYS);
    localparam int CNT_W  = (SEG_W + 1 > 5) ? SEG_W + 1 : 5;
    localparam int QUO_W  = 19;
    localparam int DD_W   = 51;
    localparam int WDIV_STEPS = 8;
    localparam int READS  = NCHAN * 4;

    localparam logic signed [65:0] ACC_HALF  = 66'sd1 <<< 29;
    localparam logic signed [65:0] Q_MAX     = 66'sd2147483647;
    localparam logic signed [65:0] Q_MIN     = -66'sd2147483647;
    localparam logic signed [65:0] P_MIN     = -66'sd2147483648;
    localparam logic signed [67:0] ONE2      = 68'sd1 <<< (2 * FRAC_BITS);
    localparam logic signed [67:0] RND_HALF  = 68'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [67:0] S32_MAX   = 68'sd2147483647;
    localparam logic signed [67:0] S32_MIN   = -68'sd2147483648;
    // ceil(2^38 / 3), exact floor division by three below 2^37
    localparam logic [36:0]        RECIP3    = 37'h15_5555_5556;

    // control and configuration
    t_state             r_state, n_state;
    logic [5:0]         r_cnt;
    logic               r_spline_mode;
    logic [4:0]         r_key_count;
    logic [15:0]        r_time_step;
    logic [SEG_W-1:0]   r_seg;
    logic [15:0]        r_tfrac;

    // key store
    logic [31:0]        r_key_mem [DEPTH];
    logic [31:0]        r_mem_q;

    // basis weights
    logic [31:0]        r_uu;
    logic [47:0]        r_uuu;
    logic signed [55:0] r_s   [4];
    logic [36:0]        r_dq  [4];
    logic [55:0]        r_wlo;
    logic signed [31:0] r_w   [4];

    // blend pipeline
    logic               r_p1_vld, r_p2_vld;
    logic [4:0]         r_p1_sel, r_p2_sel;
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic signed [31:0] r_ch [NCHAN];

    // normalisation
    logic [61:0]        r_sq;
    logic [63:0]        r_n;
    logic [4:0]         r_k;
    logic [63:0]        r_root, r_bit;
    logic [1:0]         r_comp;
    logic [DD_W-1:0]    r_dd, r_dsh;
    logic [QUO_W-1:0]   r_mag;
    logic signed [31:0] r_q  [4];
    logic signed [63:0] r_pp [9];

    // output register
    logic               r_out_vld;
    t_out_item          r_out;

    // handshakes
    logic in_acc, cfg_acc, emit_load;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign cfg_acc     = i_cfg.valid;
    assign in_acc      = i_in.valid && (r_state == ST_IDLE);
    assign emit_load   = (r_state == ST_EMIT) && (!r_out_vld || o_out.ready);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // load address and range check
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    assign wr_addr = ADDR_W'(int'(i_in.data.key_index) * NCHAN + int'(i_in.data.channel));
    assign wr_en   = in_acc && (i_in.data.kind == KIND_LOAD)
                     && (i_in.data.channel < 3'(NCHAN))
                     && (32'(i_in.data.key_index) < MAX_KEYS);

    // blend read address
    logic [SEG_W-1:0]  rd_key;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    assign rd_key  = r_seg + SEG_W'(r_cnt[1:0]);
    assign rd_addr = ADDR_W'(int'(rd_key) * NCHAN + int'(r_cnt[4:2]));
    assign rd_en   = (r_state == ST_BLEND) && (r_cnt < 6'(READS));

    // key store port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr] <= i_in.data.key_value;
        end
        if (rd_en) begin
            r_mem_q <= r_key_mem[rd_addr];
        end
    end

    // basis term of the current power of t
    logic [49:0]        tt;
    logic signed [55:0] term [4];
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: tt = 50'(r_uuu);
            2'd1: tt = 50'({r_uu, 16'b0});
            2'd2: tt = 50'({r_tfrac, 32'b0});
            default: tt = 50'd1 << 48;
        endcase
        for (int j = 0; j < 4; j++) begin
            term[j] = 56'($signed(5'(BASIS6[r_spline_mode][j * 4 + int'(r_cnt[1:0])])))
                      * 56'($signed({1'b0, tt}));
        end
    end

    // divide-by-six lanes: halved biased sum times the reciprocal of three, two halves
    logic [1:0]  wd_lane;
    logic [18:0] wd_mop;
    logic [55:0] wd_prod;
    logic [74:0] wd_full;
    always_comb begin
        wd_lane = r_cnt[2:1];
        wd_mop  = r_cnt[0] ? {1'b0, RECIP3[36:19]} : RECIP3[18:0];
        wd_prod = 56'(r_dq[wd_lane]) * 56'(wd_mop);
        wd_full = {wd_prod, 19'b0} + 75'(r_wlo);
    end

    // blend accumulate with rounding folded into the first term
    logic signed [65:0] acc_n, ch_full;
    logic signed [31:0] ch_sat;
    always_comb begin
        acc_n   = ((r_p2_sel[1:0] == 2'd0) ? ACC_HALF : r_acc) + 66'(r_prod);
        ch_full = acc_n >>> 30;
        if (r_p2_sel[4:2] < 3'd4) begin
            priority if (ch_full > Q_MAX) ch_sat = 32'(Q_MAX);
            else if (ch_full < Q_MIN)     ch_sat = 32'(Q_MIN);
            else                          ch_sat = 32'(ch_full);
        end else begin
            priority if (ch_full > Q_MAX) ch_sat = 32'(Q_MAX);
            else if (ch_full < P_MIN)     ch_sat = 32'(P_MIN);
            else                          ch_sat = 32'(ch_full);
        end
    end

    // quaternion magnitudes
    logic [30:0] m_abs [4];
    logic [63:0] m_shift;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            m_abs[c] = r_ch[c][31] ? 31'(-r_ch[c]) : 31'(r_ch[c]);
        end
        m_shift = 64'(m_abs[r_comp]) << r_k;
    end

    // square root and division steps
    logic [63:0]      sq_trial;
    logic             sq_ge, dv_ge;
    logic [QUO_W-1:0] mag_n;
    assign sq_trial = r_root + r_bit;
    assign sq_ge    = (r_n >= sq_trial);
    assign dv_ge    = (r_dd >= r_dsh);
    assign mag_n    = {r_mag[QUO_W-2:0], dv_ge};

    // product operands
    t_pp                pp_sel;
    logic signed [31:0] pp_a, pp_b;
    always_comb begin
        pp_sel = t_pp'(r_cnt[3:0]);
        unique case (pp_sel)
            PP_XX:   begin pp_a = r_q[QX]; pp_b = r_q[QX]; end
            PP_YY:   begin pp_a = r_q[QY]; pp_b = r_q[QY]; end
            PP_ZZ:   begin pp_a = r_q[QZ]; pp_b = r_q[QZ]; end
            PP_XY:   begin pp_a = r_q[QX]; pp_b = r_q[QY]; end
            PP_XZ:   begin pp_a = r_q[QX]; pp_b = r_q[QZ]; end
            PP_YZ:   begin pp_a = r_q[QY]; pp_b = r_q[QZ]; end
            PP_WX:   begin pp_a = r_q[QW]; pp_b = r_q[QX]; end
            PP_WY:   begin pp_a = r_q[QW]; pp_b = r_q[QY]; end
            PP_WZ:   begin pp_a = r_q[QW]; pp_b = r_q[QZ]; end
            default: begin pp_a = r_q[QW]; pp_b = r_q[QW]; end
        endcase
    end

    // matrix element for the current output index
    logic signed [67:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
    logic signed [67:0] e_rot, e_red;
    logic signed [31:0] e_val;
    logic               e_is_rot;
    always_comb begin
        pxx = 68'(r_pp[PP_XX]) <<< 1;
        pyy = 68'(r_pp[PP_YY]) <<< 1;
        pzz = 68'(r_pp[PP_ZZ]) <<< 1;
        pxy = 68'(r_pp[PP_XY]) <<< 1;
        pxz = 68'(r_pp[PP_XZ]) <<< 1;
        pyz = 68'(r_pp[PP_YZ]) <<< 1;
        pwx = 68'(r_pp[PP_WX]) <<< 1;
        pwy = 68'(r_pp[PP_WY]) <<< 1;
        pwz = 68'(r_pp[PP_WZ]) <<< 1;
        e_rot    = '0;
        e_is_rot = 1'b1;
        e_val    = '0;
        unique case (r_cnt[3:0])
            4'd0:  e_rot = ONE2 - pyy - pzz + RND_HALF;
            4'd1:  e_rot = pxy + pwz + RND_HALF;
            4'd2:  e_rot = pxz - pwy + RND_HALF;
            4'd4:  e_rot = pxy - pwz + RND_HALF;
            4'd5:  e_rot = ONE2 - pxx - pzz + RND_HALF;
            4'd6:  e_rot = pyz + pwx + RND_HALF;
            4'd8:  e_rot = pxz + pwy + RND_HALF;
            4'd9:  e_rot = pyz - pwx + RND_HALF;
            4'd10: e_rot = ONE2 - pxx - pyy + RND_HALF;
            4'd12: begin e_is_rot = 1'b0; e_val = r_ch[4]; end
            4'd13: begin e_is_rot = 1'b0; e_val = r_ch[5]; end
            4'd14: begin e_is_rot = 1'b0; e_val = r_ch[6]; end
            4'd15: begin e_is_rot = 1'b0; e_val = ELEM_ONE; end
            default: begin e_is_rot = 1'b0; e_val = '0; end
        endcase
        e_red = e_rot >>> FRAC_BITS;
        if (e_is_rot) begin
            priority if (e_red > S32_MAX) e_val = 32'(S32_MAX);
            else if (e_red < S32_MIN)     e_val = 32'(S32_MIN);
            else                          e_val = 32'(e_red);
        end
    end

    // time advance
    logic [CNT_W-1:0] kc, cnt_use;
    logic [16:0]      tsum;
    always_comb begin
        kc = CNT_W'(r_key_count);
        priority if (kc < CNT_W'(4))              cnt_use = CNT_W'(4);
        else if (32'(kc) > MAX_KEYS)              cnt_use = CNT_W'(MAX_KEYS);
        else                                      cnt_use = kc;
        tsum = {1'b0, r_tfrac} + {1'b0, r_time_step};
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc && i_in.data.kind == KIND_TICK) n_state = ST_USQ;
            ST_USQ:    n_state = ST_UCUBE;
            ST_UCUBE:  n_state = ST_WACC;
            ST_WACC:   if (r_cnt == 6'd3) n_state = ST_WPREP;
            ST_WPREP:  n_state = ST_WDIV;
            ST_WDIV:   if (r_cnt == 6'(WDIV_STEPS - 1)) n_state = ST_BLEND;
            ST_BLEND:  if (r_p2_vld && r_p2_sel == 5'(READS - 1)) n_state = ST_NSQ;
            ST_NSQ:    if (r_cnt == 6'd4) n_state = ST_NSHIFT;
            ST_NSHIFT: begin
                priority if (r_n == '0)     n_state = ST_PROD;
                else if (r_n[63:60] != '0)  n_state = ST_SQRT;
            end
            ST_SQRT:   if (r_cnt == 6'd31) n_state = ST_DSETUP;
            ST_DSETUP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 6'(QUO_W - 1)) begin
                    n_state = (r_comp == 2'd3) ? ST_PROD : ST_DSETUP;
                end
            end
            ST_PROD:   if (r_cnt == 6'd8) n_state = ST_EMIT;
            ST_EMIT:   if (emit_load && r_cnt[3:0] == ELEM_LAST) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spline_mode <= SPLINE_MODE_RST;
            r_key_count   <= KEY_COUNT_RST;
            r_time_step   <= TIME_STEP_RST;
            r_seg         <= '0;
            r_tfrac       <= '0;
            r_out_vld     <= 1'b0;
            r_p1_vld      <= 1'b0;
            r_p2_vld      <= 1'b0;
            r_cnt         <= '0;
        end else begin
            // configuration writes
            if (cfg_acc) begin
                unique case (i_cfg.data.index)
                    CFG_SPLINE_MODE: r_spline_mode <= i_cfg.data.data[0];
                    CFG_KEY_COUNT:   r_key_count   <= i_cfg.data.data[4:0];
                    CFG_TIME_STEP:   r_time_step   <= i_cfg.data.data;
                    default: ;
                endcase
            end
            // step counter
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (r_state != ST_EMIT || emit_load) begin
                r_cnt <= r_cnt + 6'd1;
            end
            // blend pipeline valids
            r_p1_vld <= rd_en;
            r_p2_vld <= r_p1_vld;
            // output beat
            if (emit_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            // time advance after the last element
            if (emit_load && r_cnt[3:0] == ELEM_LAST) begin
                if (tsum[16]) begin
                    r_tfrac <= '0;
                    if (CNT_W'(r_seg) < cnt_use - CNT_W'(4)) begin
                        r_seg <= r_seg + SEG_W'(1);
                    end else begin
                        r_seg <= '0;
                    end
                end else begin
                    r_tfrac <= tsum[15:0];
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_USQ: r_uu <= 32'(r_tfrac) * 32'(r_tfrac);
            ST_UCUBE: begin
                r_uuu <= 48'(r_uu) * 48'(r_tfrac);
                for (int j = 0; j < 4; j++) r_s[j] <= '0;
            end
            ST_WACC: begin
                for (int j = 0; j < 4; j++) r_s[j] <= r_s[j] + term[j];
            end
            ST_WPREP: begin
                for (int j = 0; j < 4; j++) begin
                    r_dq[j] <= 37'((40'(r_s[j] >>> 18) + 40'sd3 + (40'sd6 <<< 35)) >>> 1);
                end
            end
            ST_WDIV: begin
                if (!r_cnt[0]) begin
                    r_wlo <= wd_prod;
                end else begin
                    r_w[wd_lane] <= 32'(wd_full[74:38] - (37'd1 << 35));
                end
            end
            ST_BLEND: begin
                if (r_p1_vld) begin
                    r_prod <= 64'(r_w[r_p1_sel[1:0]]) * 64'($signed(r_mem_q));
                end
                if (r_p2_vld) begin
                    r_acc <= acc_n;
                    if (r_p2_sel[1:0] == 2'd3) r_ch[r_p2_sel[4:2]] <= ch_sat;
                end
                r_n <= '0;
                r_k <= '0;
            end
            ST_NSQ: begin
                if (r_cnt < 6'd4) r_sq <= 62'(m_abs[r_cnt[1:0]]) * 62'(m_abs[r_cnt[1:0]]);
                if (r_cnt != 6'd0) r_n <= r_n + 64'(r_sq);
            end
            ST_NSHIFT: begin
                priority if (r_n == '0) begin
                    for (int c = 0; c < 4; c++) r_q[c] <= r_ch[c];
                end else if (r_n[63:60] == '0) begin
                    r_n <= r_n << 2;
                    r_k <= r_k + 5'd1;
                end else begin
                    r_root <= '0;
                    r_bit  <= 64'd1 << 62;
                end
                r_comp <= '0;
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    r_n    <= r_n - sq_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_DSETUP: begin
                r_dd  <= (DD_W'(m_shift[32:0]) << FRAC_BITS) + DD_W'(r_root[31:1]);
                r_dsh <= DD_W'(r_root[31:0]) << (QUO_W - 1);
                r_mag <= '0;
            end
            ST_DIV: begin
                if (dv_ge) r_dd <= r_dd - r_dsh;
                r_dsh <= r_dsh >> 1;
                r_mag <= mag_n;
                if (r_cnt == 6'(QUO_W - 1)) begin
                    r_q[r_comp] <= r_ch[r_comp][31] ? -$signed(32'(mag_n))
                                                    : $signed(32'(mag_n));
                    r_comp <= r_comp + 2'd1;
                end
            end
            ST_PROD: begin
                if (r_cnt < 6'd9) r_pp[pp_sel] <= 64'(pp_a) * 64'(pp_b);
            end
            ST_EMIT: begin
                if (emit_load) begin
                    r_out.element_index <= r_cnt[3:0];
                    r_out.element_value <= e_val;
                    r_out.last          <= (r_cnt[3:0] == ELEM_LAST);
                end
            end
            default: ;
        endcase
        // blend pipeline tags
        r_p1_sel <= r_cnt[4:0];
        r_p2_sel <= r_p1_sel;
    end

endmodule

// ===== sv/sqpi_checker.sv =====
// port-level checker of the pose interpolator and its bind
module sqpi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_kind,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [3:0]         i_out_index,
    input logic signed [31:0] i_out_value,
    input logic               i_out_last
);
    import sqpi_pkg::*;

    // index expected on the next output beat
    logic [3:0] r_exp_idx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_idx <= i_out_last ? 4'd0 : r_exp_idx + 4'd1;
        end
    end

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index)
        && $stable(i_out_value))
        else $error("output beat changed while stalled");

    // elements leave in order, one matrix at a time
    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_index == r_exp_idx)
        else $error("element index out of sequence");

    // last marks element fifteen only
    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_last == (i_out_index == ELEM_LAST))
        else $error("last flag on wrong element");

    // homogeneous corner is one
    a_out_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_index == ELEM_LAST |-> i_out_value == ELEM_ONE)
        else $error("corner element not one");

    // a tick occupies the block
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind == KIND_TICK |=> !i_in_ready)
        else $error("input ready right after a tick");

endmodule

bind spline_quaternion_pose_interpolator_top sqpi_checker u_sqpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.data.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.data.element_index),
    .i_out_value (o_out.data.element_value),
    .i_out_last  (o_out.data.last)
);

// ===== sim/sqpi_pose_checker.sv =====
// pose checker: watches the channels, predicts matrix beats and compares them
module sqpi_pose_checker
    import sqpi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    sqpi_stream_if cfg_if,
    sqpi_stream_if in_if,
    sqpi_stream_if out_if,
    output int    o_errors,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the block state
    logic [31:0] keys [16*NCHAN];
    logic        mode_q;
    logic [4:0]  count_q;
    logic [15:0] step_q;
    logic [3:0]  seg_q;
    logic [15:0] frac_q;

    t_out_item   pose_beats [$];
    int          n_ticks;

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint clamp_s32(longint v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    function automatic bit [63:0] root_floor(bit [63:0] n);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // round at FRAC_BITS, ties up
    function automatic longint round_frac(longint e);
        return (e + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // blend the current segment and queue the 16 matrix beats
    task automatic predict_pose();
        longint    u, s, acc, qw, qx, qy, qz, one2;
        longint    tt [4];
        longint    wt [4];
        longint    ch [NCHAN];
        longint    q [4];
        longint    el [16];
        bit [63:0] mag [4];
        bit [63:0] nsq, r, v;
        int        sh, idx;
        t_out_item b;
        u = longint'(frac_q);
        tt[0] = u * u * u;
        tt[1] = (u * u) <<< 16;
        tt[2] = u <<< 32;
        tt[3] = 64'sd1 <<< 48;
        for (int j = 0; j < 4; j++) begin
            s = 0;
            for (int i = 0; i < 4; i++) s += longint'(BASIS6[mode_q][j*4+i]) * tt[i];
            wt[j] = floor_div(s + (64'sd3 <<< 18), 64'sd6 <<< 18);
        end
        for (int c = 0; c < NCHAN; c++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                idx = int'(seg_q) + j;
                if (idx < 16) acc += wt[j] * longint'($signed(keys[idx*NCHAN + c]));
            end
            ch[c] = (acc + (64'sd1 <<< 29)) >>> 30;
        end
        // normalise unless the quaternion is zero
        nsq = 0;
        for (int i = 0; i < 4; i++) begin
            q[i] = ch[i];
            if (q[i] > 64'sd2147483647) q[i] = 64'sd2147483647;
            if (q[i] < -64'sd2147483647) q[i] = -64'sd2147483647;
            mag[i] = (q[i] < 0) ? 64'(-q[i]) : 64'(q[i]);
            nsq += mag[i] * mag[i];
        end
        if (nsq != 0) begin
            sh = 0;
            while (nsq < (64'd1 << 60)) begin
                nsq <<= 2;
                sh++;
            end
            r = root_floor(nsq);
            for (int i = 0; i < 4; i++) begin
                v = (mag[i] << sh) << FRAC_BITS;
                v = (v + r / 2) / r;
                q[i] = (q[i] < 0) ? -longint'(v) : longint'(v);
            end
        end
        qw = q[QW]; qx = q[QX]; qy = q[QY]; qz = q[QZ];
        one2 = 64'sd1 <<< (2*FRAC_BITS);
        el[0]  = round_frac(one2 - 2*qy*qy - 2*qz*qz);
        el[1]  = round_frac(2*qx*qy + 2*qw*qz);
        el[2]  = round_frac(2*qx*qz - 2*qw*qy);
        el[3]  = 0;
        el[4]  = round_frac(2*qx*qy - 2*qw*qz);
        el[5]  = round_frac(one2 - 2*qx*qx - 2*qz*qz);
        el[6]  = round_frac(2*qy*qz + 2*qw*qx);
        el[7]  = 0;
        el[8]  = round_frac(2*qx*qz + 2*qw*qy);
        el[9]  = round_frac(2*qy*qz - 2*qw*qx);
        el[10] = round_frac(one2 - 2*qx*qx - 2*qy*qy);
        el[11] = 0;
        el[12] = ch[4];
        el[13] = ch[5];
        el[14] = ch[6];
        el[15] = 64'sd1 <<< FRAC_BITS;
        for (int j = 0; j < 16; j++) begin
            b.element_index = 4'(j);
            b.element_value = 32'(clamp_s32(el[j]));
            b.last          = (4'(j) == ELEM_LAST);
            pose_beats.push_back(b);
        end
    endtask

    // advance fraction and segment after a tick
    task automatic advance_time();
        logic [16:0] sum;
        int          cnt;
        cnt = (count_q < 4) ? 4 : ((count_q > 16) ? 16 : int'(count_q));
        sum = {1'b0, frac_q} + {1'b0, step_q};
        if (sum[16]) begin
            frac_q = '0;
            if (int'(seg_q) < cnt - 4) seg_q = seg_q + 4'd1;
            else seg_q = '0;
        end else begin
            frac_q = sum[15:0];
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want, got;
        t_in_item  it;
        t_cfg_item cw;
        if (!i_rst_n) begin
            mode_q   <= SPLINE_MODE_RST;
            count_q  <= KEY_COUNT_RST;
            step_q   <= TIME_STEP_RST;
            seg_q    <= '0;
            frac_q   <= '0;
            o_errors <= 0;
            n_ticks  <= 0;
            pose_beats.delete();
        end else begin
            // register writes
            if (cfg_if.valid && cfg_if.ready) begin
                cw = cfg_if.data;
                case (cw.index)
                    CFG_SPLINE_MODE: mode_q = cw.data[0];
                    CFG_KEY_COUNT:   count_q = cw.data[4:0];
                    CFG_TIME_STEP:   step_q = cw.data;
                    default: ;
                endcase
            end
            // input beats
            if (in_if.valid && in_if.ready) begin
                it = in_if.data;
                if (it.kind == KIND_TICK) begin
                    predict_pose();
                    advance_time();
                    n_ticks = n_ticks + 1;
                end else if (it.channel < NCHAN) begin
                    keys[int'(it.key_index)*NCHAN + int'(it.channel)] = it.key_value;
                end
            end
            // output beats
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (pose_beats.size() == 0) begin
                    $error("unexpected matrix beat, index %0d", got.element_index);
                    o_errors = o_errors + 1;
                end else begin
                    want = pose_beats.pop_front();
                    if (got.element_index !== want.element_index) begin
                        $error("element_index: expected %0d, got %0d",
                               want.element_index, got.element_index);
                        o_errors = o_errors + 1;
                    end
                    if (got.element_value !== want.element_value) begin
                        $error("element_value[%0d]: expected %0d, got %0d",
                               want.element_index, want.element_value, got.element_value);
                        o_errors = o_errors + 1;
                    end
                    if (got.last !== want.last) begin
                        $error("last[%0d]: expected %0b, got %0b",
                               want.element_index, want.last, got.last);
                        o_errors = o_errors + 1;
                    end
                end
            end
        end
        o_pending <= pose_beats.size();
    end
endmodule

// ===== sim/tb_spline_quaternion_pose_interpolator_top.sv =====
// testbench top: clock, reset, stimulus and verdict for the pose interpolator
module tb_spline_quaternion_pose_interpolator_top;
    import sqpi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 3000;

    logic i_clk;
    logic i_rst_n;
    int   n_errors, n_pending;
    int   n_cycles = 0;
    bit   calm;
    bit   hold_req;
    int   n_items;

    sqpi_stream_if #(.t_payload(t_cfg_item)) cfg_if ();
    sqpi_stream_if #(.t_payload(t_in_item))  in_if ();
    sqpi_stream_if #(.t_payload(t_out_item)) out_if ();

    spline_quaternion_pose_interpolator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sqpi_pose_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg_if    (cfg_if),
        .in_if     (in_if),
        .out_if    (out_if),
        .o_errors  (n_errors),
        .o_pending (n_pending)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_spline_quaternion_pose_interpolator_top: done, errors");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    // offer one beat, with random gaps in front
    task automatic push_beat(t_in_item it);
        while (!calm && $urandom_range(99) < 21) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        n_items++;
    endtask

    task automatic load_key(logic [3:0] k, logic [2:0] c, logic [31:0] v);
        t_in_item it;
        it.kind = KIND_LOAD;
        it.key_index = k;
        it.channel = c;
        it.key_value = v;
        push_beat(it);
    endtask

    task automatic tick();
        t_in_item it;
        it = 40'({$urandom, $urandom});
        it.kind = KIND_TICK;
        push_beat(it);
    endtask

    // key value: mostly moderate so rotations stay meaningful, some full range
    function automatic logic [31:0] rand_key();
        if ($urandom_range(99) < 35) return $urandom;
        return 32'($signed(int'($urandom_range(262143)) - 131072));
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for all matrix beats, then let a trailing load settle
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_regs(logic mode, logic [4:0] cnt, logic [15:0] stp);
        drain();
        write_reg(CFG_SPLINE_MODE, {15'd0, mode});
        write_reg(CFG_KEY_COUNT, {11'd0, cnt});
        write_reg(CFG_TIME_STEP, stp);
    endtask

    // random beats: ticks with loads in between, a few ignored channel-7 loads
    task automatic random_run(int n);
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 40) tick();
            else if (p < 45) load_key(4'($urandom), 3'd7, $urandom);
            else load_key(4'($urandom), 3'($urandom_range(NCHAN - 1)), rand_key());
        end
    endtask

    logic        ph_mode [7];
    logic [4:0]  ph_count [7];
    logic [15:0] ph_step [7];

    initial begin
        i_rst_n      = 1'b0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        n_items      = 0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_regs(SPLINE_MODE_RST, KEY_COUNT_RST, TIME_STEP_RST);

        // fill every key; keys 0..3 carry a zero quaternion
        for (int k = 0; k < 16; k++)
            for (int c = 0; c < NCHAN; c++)
                load_key(4'(k), 3'(c), (k < 4 && c < 4) ? 32'd0 : rand_key());

        // zero quaternion at segment 0, t = 0
        tick();
        // extreme positions and clamped quaternion components
        load_key(4'd1, 3'd4, 32'h7fffffff);
        load_key(4'd2, 3'd4, 32'h7fffffff);
        load_key(4'd1, 3'd5, 32'h80000000);
        load_key(4'd2, 3'd5, 32'h80000000);
        load_key(4'd1, 3'd6, 32'hffffffff);
        load_key(4'd0, 3'd0, 32'h80000000);
        load_key(4'd1, 3'd0, 32'h7fffffff);
        load_key(4'd2, 3'd1, 32'h80000000);
        load_key(4'd3, 3'd2, 32'h7fffffff);
        load_key(4'd15, 3'd7, 32'h12345678);
        tick();
        tick();
        // key 1 alone with unit quaternion
        load_key(4'd1, 3'd0, 32'h00010000);
        load_key(4'd1, 3'd1, 32'd0);
        load_key(4'd1, 3'd2, 32'd0);
        load_key(4'd1, 3'd3, 32'd0);
        tick();

        ph_mode  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        ph_count = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd5, 5'd16, 5'd8};
        ph_step  = '{16'd65535, 16'd1, 16'd21845, 16'd9000, 16'd0, 16'd30000, 16'd16384};
        for (int ph = 0; ph < 7; ph++) begin
            set_regs(ph_mode[ph], ph_count[ph], ph_step[ph]);
            calm = (ph == 3);
            if (ph == 2) hold_req = 1'b1;
            random_run(ph == 0 ? 60 : 32);
        end
        calm = 1'b0;

        drain();
        repeat (300) @(posedge i_clk);
        $display("run: %0d input beats, %0d ticks, both bases, key counts 0..31, steps 0..65535",
                 n_items, u_chk.n_ticks);
        $display("run: zero and clamped quaternions, saturated positions, one long output hold");
        if (n_errors == 0 && n_pending == 0) begin
            $display("tb_spline_quaternion_pose_interpolator_top: done, clean");
        end else begin
            $display("tb_spline_quaternion_pose_interpolator_top: done, errors");
        end
        $finish;
    end
endmodule
